FILE: hw/rtl/ssp_pkg.sv
package ssp_pkg;

	localparam int unsigned SLEW_W = 10;
	localparam int unsigned LIM_W  = 13;
	localparam int unsigned CDEG_W = 15;

	localparam logic [7:0]        MAX_DEG       = 8'd180;
	localparam logic [CDEG_W-1:0] MAX_CDEG      = 15'd18000;
	localparam logic [11:0]       PULSE_MIN     = 12'd500;
	localparam logic [LIM_W-1:0]  MIN_STEP_CDEG = 13'd10;
	localparam int                DEADBAND_CDEG = 5;
	localparam logic [SLEW_W-1:0] SLEW_RESET    = 10'd120;
	localparam logic [SLEW_W-1:0] SLEW_LO       = 10'd1;
	localparam logic [SLEW_W-1:0] SLEW_HI       = 10'd1000;

	typedef enum logic [1:0] {
		OP_SET  = 2'd0,
		OP_UP   = 2'd1,
		OP_DOWN = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	// decoded command, zero-length ticks become no-ops
	typedef enum logic [2:0] {
		K_SET,
		K_UP,
		K_DOWN,
		K_TICK,
		K_NOP
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       amount;
		logic [LIM_W-1:0] lim;
	} cmd_t;

endpackage

FILE: hw/rtl/ssp_front.sv
module ssp_front import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SLEW_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        amount,
	input  logic [15:0]       tick_us,
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output cmd_t              cmd
);

	localparam int unsigned PROD_W  = SLEW_W + 16;
	localparam int unsigned RECIP_K = 40;
	// ceil(2^40 / 10000), exact floor division for products below 2^26
	localparam logic [26:0] RECIP_10K = 27'd109951163;
	localparam int unsigned WIDE_W = PROD_W + 27;

	logic [SLEW_W-1:0] slew_q;

	logic              valid_s1;
	kind_t             kind_s1;
	logic [7:0]        amount_s1;
	logic [PROD_W-1:0] prod_s1;

	logic              valid_s2;
	kind_t             kind_s2;
	logic [7:0]        amount_s2;
	logic [LIM_W-1:0]  quot_s2;

	logic              s2_free;
	logic              s1_free;
	logic              in_fire;
	logic              s1_move;
	kind_t             kind_in;
	logic [7:0]        amount_in;
	logic [WIDE_W-1:0] wide;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slew_q <= SLEW_RESET;
		end else if (cfg_valid) begin
			if (cfg_data < SLEW_LO)
				slew_q <= SLEW_LO;
			else if (cfg_data > SLEW_HI)
				slew_q <= SLEW_HI;
			else
				slew_q <= cfg_data;
		end
	end

	always_comb begin
		amount_in = amount;
		case (opcode)
			OP_SET: begin
				kind_in = K_SET;
				if (amount > MAX_DEG)
					amount_in = MAX_DEG;
			end
			OP_UP:   kind_in = K_UP;
			OP_DOWN: kind_in = K_DOWN;
			default: kind_in = (tick_us == 16'd0) ? K_NOP : K_TICK;
		endcase
	end

	assign s2_free  = !valid_s2 || cmd_ready;
	assign s1_move  = valid_s1 && s2_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_ready = s1_free;
	assign in_fire  = in_valid && in_ready;

	assign wide = {27'd0, prod_s1} * {{PROD_W{1'b0}}, RECIP_10K};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= in_fire;
			if (s2_free)
				valid_s2 <= s1_move;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			kind_s1   <= kind_in;
			amount_s1 <= amount_in;
			prod_s1   <= {16'd0, slew_q} * {{SLEW_W{1'b0}}, tick_us};
		end
		if (s1_move) begin
			kind_s2   <= kind_s1;
			amount_s2 <= amount_s1;
			quot_s2   <= wide[RECIP_K +: LIM_W];
		end
	end

	assign cmd_valid   = valid_s2;
	assign cmd.kind    = kind_s2;
	assign cmd.amount  = amount_s2;
	assign cmd.lim     = (quot_s2 < MIN_STEP_CDEG) ? MIN_STEP_CDEG : quot_s2;

endmodule

FILE: hw/rtl/ssp_queue.sv
module ssp_queue import ssp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_data;
	end

endmodule

FILE: hw/rtl/ssp_back.sv
module ssp_back import ssp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [11:0]       pulse_width,
	output logic [CDEG_W-1:0] commanded_cdeg,
	output logic [7:0]        angle_rounded,
	output logic [7:0]        target_deg
);

	// ceil(2^17/9) and ceil(2^21/100), exact over the commanded range
	localparam logic [13:0] RECIP_9   = 14'd14564;
	localparam logic [14:0] RECIP_100 = 15'd20972;

	logic              out_valid_q;
	logic [7:0]        target_q;
	logic [CDEG_W-1:0] commanded_q;

	logic              pop;
	logic [8:0]        up_sum;
	logic [CDEG_W-1:0] tgt_cdeg;
	logic signed [15:0] err;
	logic signed [15:0] lim_s;
	logic signed [15:0] step;
	logic signed [15:0] next_c;
	logic              in_band;
	logic [28:0]       p9;
	logic [29:0]       p100;

	assign pop       = cmd_valid && (!out_valid_q || out_ready);
	assign cmd_ready = !out_valid_q || out_ready;

	assign up_sum   = {1'b0, target_q} + {1'b0, cmd.amount};
	assign tgt_cdeg = CDEG_W'(target_q) * CDEG_W'(100);
	assign err      = $signed({1'b0, tgt_cdeg}) - $signed({1'b0, commanded_q});
	assign lim_s    = $signed({3'b000, cmd.lim});
	assign in_band  = (err > -16'sd5) && (err < 16'sd5);

	always_comb begin
		if (err > lim_s)
			step = lim_s;
		else if (err < -lim_s)
			step = -lim_s;
		else
			step = err;
	end

	assign next_c = $signed({1'b0, commanded_q}) + step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			target_q    <= '0;
			commanded_q <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				out_valid_q <= 1'b1;
				case (cmd.kind)
					K_SET: begin
						target_q    <= cmd.amount;
						commanded_q <= CDEG_W'(cmd.amount) * CDEG_W'(100);
					end
					K_UP: begin
						target_q <= (up_sum > {1'b0, MAX_DEG}) ? MAX_DEG : up_sum[7:0];
					end
					K_DOWN: begin
						target_q <= (cmd.amount >= target_q) ? 8'd0 : target_q - cmd.amount;
					end
					K_TICK: begin
						if (!in_band)
							commanded_q <= (next_c > $signed({1'b0, MAX_CDEG})) ?
								MAX_CDEG : next_c[CDEG_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// pulse and rounded angle follow the held commanded angle
	assign p9   = (29'(commanded_q) + 29'd4) * 29'(RECIP_9);
	assign p100 = (30'(commanded_q) + 30'd50) * 30'(RECIP_100);

	assign out_valid      = out_valid_q;
	assign commanded_cdeg = commanded_q;
	assign target_deg     = target_q;
	assign pulse_width    = PULSE_MIN + p9[28:17];
	assign angle_rounded  = p100[28:21];

endmodule

FILE: hw/rtl/servo_slew_limited_pwm.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+------------------------------------
// cfg      | in        | cfg_valid / cfg_ready  | cfg_data (slew rate, deg/s)
// in       | in        | in_valid / in_ready    | opcode, amount, tick_us
// out      | out       | out_valid / out_ready  | pulse_width, commanded_cdeg,
//          |           |                        | angle_rounded, target_deg
//
// one transfer per cycle on each side while nothing stalls; a command's result is registered
// after its input transfer through two front stages, the queue entry, then the state update
// the slew-limit multiply and the divide by 10000 set the two front stages
// arst_n clears the pipeline, the queue and the state: target 0, angle 0, pulse 500 us,
// slew rate 120 deg/s; cfg_ready is always high
// a held result stops the back end only; the front keeps taking commands until the
// queue and both front stages fill, then in_ready drops
module servo_slew_limited_pwm import ssp_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [SLEW_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        amount,
	input  logic [15:0]       tick_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [11:0]       pulse_width,
	output logic [CDEG_W-1:0] commanded_cdeg,
	output logic [7:0]        angle_rounded,
	output logic [7:0]        target_deg
);

	// decoded commands with their slew limit, front to queue
	logic f_valid;
	logic f_ready;
	cmd_t f_cmd;

	// queue to back end
	logic b_valid;
	logic b_ready;
	cmd_t b_cmd;

	// front: slew register, opcode decode, limit = max(10, slew * tick / 10000)
	ssp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.amount    (amount),
		.tick_us   (tick_us),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	// short queue so the front keeps going while a result is held
	ssp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_cmd),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_cmd)
	);

	// back: target and commanded angle, held in the output register itself
	ssp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (b_valid),
		.cmd_ready      (b_ready),
		.cmd            (b_cmd),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pulse_width    (pulse_width),
		.commanded_cdeg (commanded_cdeg),
		.angle_rounded  (angle_rounded),
		.target_deg     (target_deg)
	);

endmodule

FILE: tb/tb_servo_slew_limited_pwm.sv
module tb_servo_slew_limited_pwm;
	import ssp_pkg::*;

	// generous cap on the whole run, far above the slowest legal run
	localparam int CYCLE_LIMIT = 300000;
	// settle time after the last result before a config write
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_PHASE_ITEMS = 55;

	// what the block reports after one command
	typedef struct {
		logic [11:0]       pulse_width;
		logic [CDEG_W-1:0] commanded_cdeg;
		logic [7:0]        angle_rounded;
		logic [7:0]        target_deg;
	} servo_status_t;

	// tracks the servo state and holds the status each accepted command should produce
	class servo_scoreboard;
		logic [7:0]        target_deg;
		logic [CDEG_W-1:0] commanded_cdeg;
		logic [11:0]       pulse_width;
		logic [SLEW_W-1:0] slew_rate;
		servo_status_t     status_q[$];
		int errors;
		int results_checked;
		int sets;
		int steps;
		int ticks;
		int deadband_hits;
		int floor_hits;

		function new();
			target_deg     = '0;
			commanded_cdeg = '0;
			pulse_width    = PULSE_MIN;
			slew_rate      = SLEW_RESET;
		endfunction

		function void apply_slew(logic [SLEW_W-1:0] value);
			// writes saturate into 1..1000
			if (value < SLEW_LO)
				slew_rate = SLEW_LO;
			else if (value > SLEW_HI)
				slew_rate = SLEW_HI;
			else
				slew_rate = value;
		endfunction

		function void drive_to(int cdeg);
			if (cdeg > int'(MAX_CDEG))
				cdeg = int'(MAX_CDEG);
			commanded_cdeg = cdeg[CDEG_W-1:0];
			pulse_width    = 12'(int'(PULSE_MIN) + (cdeg + 4) / 9);
		endfunction

		function void slew_toward_target(logic [15:0] tick_us);
			int err;
			int unsigned lim;
			if (tick_us == 16'd0)
				return;
			err = int'(target_deg) * 100 - int'(commanded_cdeg);
			if (err > -DEADBAND_CDEG && err < DEADBAND_CDEG) begin
				deadband_hits++;
				return;
			end
			lim = (int'(slew_rate) * int'(tick_us)) / 10000;
			if (lim < int'(MIN_STEP_CDEG)) begin
				lim = MIN_STEP_CDEG;
				floor_hits++;
			end
			if (err > int'(lim))
				err = lim;
			if (err < -int'(lim))
				err = -int'(lim);
			drive_to(int'(commanded_cdeg) + err);
		endfunction

		function void advance_servo(opcode_t op, logic [7:0] amount, logic [15:0] tick_us);
			int sum;
			case (op)
				OP_SET: begin
					sets++;
					target_deg = (amount > MAX_DEG) ? MAX_DEG : amount;
					drive_to(int'(target_deg) * 100);
				end
				OP_UP: begin
					steps++;
					sum = int'(target_deg) + int'(amount);
					target_deg = (sum > int'(MAX_DEG)) ? MAX_DEG : sum[7:0];
				end
				OP_DOWN: begin
					steps++;
					target_deg = (amount >= target_deg) ? 8'd0 : target_deg - amount;
				end
				default: begin
					ticks++;
					slew_toward_target(tick_us);
				end
			endcase
		endfunction

		// called for every accepted input transfer
		function void note_command(opcode_t op, logic [7:0] amount, logic [15:0] tick_us);
			servo_status_t s;
			advance_servo(op, amount, tick_us);
			s.pulse_width    = pulse_width;
			s.commanded_cdeg = commanded_cdeg;
			s.angle_rounded  = 8'((int'(commanded_cdeg) + 50) / 100);
			s.target_deg     = target_deg;
			status_q.push_back(s);
		endfunction

		// called for every accepted output transfer
		function void check_result(logic [11:0] pulse, logic [CDEG_W-1:0] cdeg,
				logic [7:0] angle, logic [7:0] tgt);
			servo_status_t e;
			if (status_q.size() == 0) begin
				$error("result transfer with no command outstanding");
				errors++;
				return;
			end
			e = status_q.pop_front();
			results_checked++;
			if (pulse !== e.pulse_width) begin
				$error("pulse_width mismatch: expected %0d, got %0d", e.pulse_width, pulse);
				errors++;
			end
			if (cdeg !== e.commanded_cdeg) begin
				$error("commanded_cdeg mismatch: expected %0d, got %0d",
					e.commanded_cdeg, cdeg);
				errors++;
			end
			if (angle !== e.angle_rounded) begin
				$error("angle_rounded mismatch: expected %0d, got %0d",
					e.angle_rounded, angle);
				errors++;
			end
			if (tgt !== e.target_deg) begin
				$error("target_deg mismatch: expected %0d, got %0d", e.target_deg, tgt);
				errors++;
			end
		endfunction

		function int pending();
			return status_q.size();
		endfunction
	endclass

	// every input starts at a known value
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SLEW_W-1:0] cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        opcode = OP_SET;
	logic [7:0]        amount = '0;
	logic [15:0]       tick_us = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [11:0]       pulse_width;
	logic [CDEG_W-1:0] commanded_cdeg;
	logic [7:0]        angle_rounded;
	logic [7:0]        target_deg;

	servo_scoreboard sb;
	int cycles = 0;
	int burst_left = 0;     // commands left in the current sender burst
	int slew_writes = 0;
	int hold_requests = 0;  // bumped by the stimulus to ask for a long receiver hold
	int hold_served = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	servo_slew_limited_pwm u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.amount         (amount),
		.tick_us        (tick_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.pulse_width    (pulse_width),
		.commanded_cdeg (commanded_cdeg),
		.angle_rounded  (angle_rounded),
		.target_deg     (target_deg)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// receiver: check the transfer seen at this edge, then pick ready for the next cycle
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_result(pulse_width, commanded_cdeg, angle_rounded, target_deg);
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left = 80;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_mode_left = $urandom_range(20, 150);
		end
		rx_mode_left--;
		if (hold_left > 0) begin
			// long hold-off so the pipe and the queue fill and in_ready drops
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 5) == 0);
				default: out_ready <= (cycles % 4 != 0);
			endcase
		end
	end

	// runaway guard
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("[servo_slew_limited_pwm] ERROR");
		$finish;
	end

	// offer one command and wait for its transfer; gaps fall between bursts
	task automatic send_command(input opcode_t op, input logic [7:0] amt,
			input logic [15:0] us);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
		end
		burst_left--;
		in_valid <= 1'b1;
		opcode   <= op;
		amount   <= amt;
		tick_us  <= us;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_command(op, amt, us);
	endtask

	task automatic send_random_command();
		int pick;
		opcode_t op;
		logic [7:0] amt;
		logic [15:0] us;
		pick = $urandom_range(0, 99);
		// ticks dominate so the angle actually travels, lands and sits in the deadband
		if (pick < 12)
			op = OP_SET;
		else if (pick < 24)
			op = OP_UP;
		else if (pick < 36)
			op = OP_DOWN;
		else
			op = OP_TICK;
		// ignored fields carry random noise as well
		amt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
			: 8'($urandom_range(0, 20));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			us = 16'd0;
		else if (pick == 1)
			us = 16'hFFFF;
		else if (pick < 5)
			us = 16'($urandom_range(0, 65535));
		else
			us = 16'($urandom_range(1, 20000));
		send_command(op, amt, us);
	endtask

	// lower valid, let every result come home, then let the pipe settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_slew(input logic [SLEW_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.apply_slew(value);
		slew_writes++;
	endtask

	task automatic run_random_phase(input logic [SLEW_W-1:0] slew);
		write_slew(slew);
		repeat (RANDOM_PHASE_ITEMS) send_random_command();
	endtask

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset slew rate: range ends, saturation, zero tick, long and short ticks
		send_command(OP_SET, 8'd0, 16'd0);
		send_command(OP_SET, 8'd180, 16'hFFFF);
		send_command(OP_SET, 8'd255, 16'd0);       // set above 180 saturates
		send_command(OP_UP, 8'd255, 16'd0);        // step up past the top
		send_command(OP_DOWN, 8'd255, 16'd0);      // step down past zero
		send_command(OP_TICK, 8'd255, 16'd0);      // zero-length tick is a no-op
		send_command(OP_TICK, 8'd0, 16'hFFFF);
		send_command(OP_TICK, 8'd0, 16'd1);        // limit raised to the 0.1 deg floor
		send_command(OP_SET, 8'd90, 16'd0);
		send_command(OP_DOWN, 8'd90, 16'd0);
		send_command(OP_UP, 8'd1, 16'd0);
		send_command(OP_TICK, 8'd0, 16'd30000);

		// fastest slew: land just inside the deadband, then just outside it
		write_slew(SLEW_HI);
		send_command(OP_SET, 8'd0, 16'd0);
		send_command(OP_UP, 8'd1, 16'd0);
		send_command(OP_TICK, 8'd0, 16'd970);      // 3 cdeg short of target
		send_command(OP_TICK, 8'd0, 16'hFFFF);     // inside deadband, nothing moves
		send_command(OP_DOWN, 8'd1, 16'd0);
		send_command(OP_TICK, 8'd0, 16'd920);      // 5 cdeg above target
		send_command(OP_TICK, 8'd0, 16'd1);        // edge of deadband still moves

		// a zero write saturates to the slowest rate
		write_slew('0);
		send_command(OP_SET, 8'd0, 16'd0);
		send_command(OP_UP, 8'd5, 16'd0);
		send_command(OP_TICK, 8'd0, 16'd1);
		send_command(OP_TICK, 8'd0, 16'hFFFF);

		// first random phase runs with the long receiver hold and a gapless sender
		wait_idle();
		hold_requests++;
		burst_left = 200;
		repeat (RANDOM_PHASE_ITEMS) send_random_command();

		run_random_phase({SLEW_W{1'b1}});         // all ones, saturates to the top
		run_random_phase(10'd1001);
		run_random_phase(SLEW_LO);
		run_random_phase(SLEW_HI);
		run_random_phase(SLEW_RESET);
		run_random_phase(SLEW_W'($urandom_range(0, 1023)));

		wait_idle();
		repeat (10) @(posedge clk);

		$display("covered %0d sets, %0d steps, %0d ticks over %0d slew writes",
			sb.sets, sb.steps, sb.ticks, slew_writes);
		$display("checked %0d results, %0d deadband ticks, %0d floor-limited moves",
			sb.results_checked, sb.deadband_hits, sb.floor_hits);
		if (sb.errors == 0)
			$display("[servo_slew_limited_pwm] OK");
		else
			$display("[servo_slew_limited_pwm] ERROR");
		$finish;
	end

endmodule

FILE: servo_slew_limited_pwm.f
hw/rtl/ssp_pkg.sv
hw/rtl/ssp_front.sv
hw/rtl/ssp_queue.sv
hw/rtl/ssp_back.sv
hw/rtl/servo_slew_limited_pwm.sv
tb/tb_servo_slew_limited_pwm.sv
